### rtl/assert_macros.svh
// Assertion macros used by the top level of the matrix-vector multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge of clk_i while rst_ni is high.
`define MVM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, in reset too.
`define MVM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define MVM_ASSERT(name, prop, msg)
`define MVM_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

### rtl/mvm_pkg.sv
// Types and constants of the matrix-vector multiplier.
package mvm_pkg;

  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 36;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;
  localparam int IDX_LIMIT = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD_MAT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_VEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [CNT_W-1:0] ROWS_RESET = 5'd4;
  localparam logic [CNT_W-1:0] COLS_RESET = 5'd4;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
  } mvm_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_row;
    logic signed [ACC_W-1:0] result_value;
    logic                    last_row;
  } mvm_out_t;

  // One multiply-accumulate slot issued by the controller.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last_col;
    logic             last_row;
    logic             zero;
  } mvm_issue_t;

  // Store write strobes for an accepted load transaction.
  typedef struct packed {
    logic mat_we;
    logic vec_we;
  } mvm_load_t;

endpackage

### rtl/mvm_ctrl.sv
// Controller: configuration registers, load decode and the row/column sequencer.
module mvm_ctrl #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mvm_pkg::mvm_in_t               in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mvm_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output mvm_pkg::mvm_issue_t            issue_o,
  output mvm_pkg::mvm_load_t             load_o
);
  import mvm_pkg::*;

  localparam int EFF_ROWS = (MAX_ROWS < IDX_LIMIT) ? MAX_ROWS : IDX_LIMIT;
  localparam int EFF_COLS = (MAX_COLS < IDX_LIMIT) ? MAX_COLS : IDX_LIMIT;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] row_q, row_d, col_q, col_d;
  logic [CNT_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [CNT_W-1:0] nr, nc;
  logic             accept, last_col, last_row;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q == S_RUN);
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= ROWS_RESET;
      cols_cfg_q <= COLS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROWS: rows_cfg_q <= cfg_data_i;
        REG_COLS: cols_cfg_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Counts beyond what the stores hold saturate.
  assign nr = (rows_cfg_q > CNT_W'(EFF_ROWS)) ? CNT_W'(EFF_ROWS) : rows_cfg_q;
  assign nc = (cols_cfg_q > CNT_W'(EFF_COLS)) ? CNT_W'(EFF_COLS) : cols_cfg_q;

  assign load_o.mat_we = accept && (in_i.cmd == CMD_LOAD_MAT)
                         && ({1'b0, in_i.row_index} < CNT_W'(EFF_ROWS))
                         && ({1'b0, in_i.col_index} < CNT_W'(EFF_COLS));
  assign load_o.vec_we = accept && (in_i.cmd == CMD_LOAD_VEC)
                         && ({1'b0, in_i.col_index} < CNT_W'(EFF_COLS));

  // With no columns in use each row still takes one slot whose product is zero.
  assign last_col = (nc == '0) || (({1'b0, col_q} + CNT_W'(1)) == nc);
  assign last_row = (({1'b0, row_q} + CNT_W'(1)) == nr);

  always_comb begin
    issue_o.valid    = (state_q == S_RUN);
    issue_o.row      = row_q;
    issue_o.col      = col_q;
    issue_o.first    = (col_q == '0);
    issue_o.last_col = last_col;
    issue_o.last_row = last_row;
    issue_o.zero     = (nc == '0);
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_i.cmd == CMD_START) && (nr != '0)) begin
          state_d = S_RUN;
          row_d   = '0;
          col_d   = '0;
        end
      end
      S_RUN: begin
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            state_d = S_IDLE;
          end else begin
            row_d = row_q + IDX_W'(1);
          end
        end else begin
          col_d = col_q + IDX_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

### rtl/mvm_dp.sv
// Datapath: matrix and vector stores, multiplier and accumulator pipeline.
module mvm_dp #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvm_pkg::mvm_in_t    in_i,
  input  mvm_pkg::mvm_load_t  load_i,
  input  mvm_pkg::mvm_issue_t issue_i,
  output logic                result_valid_o,
  output mvm_pkg::mvm_out_t   result_o
);
  import mvm_pkg::*;

  localparam int EFF_ROWS = (MAX_ROWS < IDX_LIMIT) ? MAX_ROWS : IDX_LIMIT;
  localparam int EFF_COLS = (MAX_COLS < IDX_LIMIT) ? MAX_COLS : IDX_LIMIT;
  localparam int MDEPTH   = EFF_ROWS * EFF_COLS;
  localparam int MADDR_W  = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int VADDR_W  = (EFF_COLS > 1) ? $clog2(EFF_COLS) : 1;

  logic signed [ELEM_W-1:0] mat_mem [MDEPTH];
  logic signed [ELEM_W-1:0] vec_mem [EFF_COLS];

  logic [MADDR_W-1:0] mat_waddr, mat_raddr;
  logic [VADDR_W-1:0] vec_waddr, vec_raddr;

  logic signed [ELEM_W-1:0] m_q, v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  mvm_issue_t               tag1_q, tag2_q;
  logic                     valid1_q, valid2_q, out_valid_q;
  logic [IDX_W-1:0]         row3_q;
  logic                     last3_q;

  // Row-major addressing.
  assign mat_waddr = MADDR_W'(32'(in_i.row_index) * EFF_COLS + 32'(in_i.col_index));
  assign mat_raddr = MADDR_W'(32'(issue_i.row) * EFF_COLS + 32'(issue_i.col));
  assign vec_waddr = VADDR_W'(in_i.col_index);
  assign vec_raddr = VADDR_W'(issue_i.col);

  always_ff @(posedge clk_i) begin
    if (load_i.mat_we) begin
      mat_mem[mat_waddr] <= in_i.element_value;
    end
    if (issue_i.valid) begin
      m_q <= mat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.vec_we) begin
      vec_mem[vec_waddr] <= in_i.element_value;
    end
    if (issue_i.valid) begin
      v_q <= vec_mem[vec_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid1_q    <= issue_i.valid;
      valid2_q    <= valid1_q;
      out_valid_q <= valid2_q && tag2_q.last_col;
    end
  end

  assign acc_d = tag2_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    tag1_q <= issue_i;
    tag2_q <= tag1_q;
    if (valid1_q) begin
      prod_q <= tag1_q.zero ? '0 : PROD_W'(m_q * v_q);
    end
    if (valid2_q) begin
      acc_q   <= acc_d;
      row3_q  <= tag2_q.row;
      last3_q <= tag2_q.last_row;
    end
  end

  assign result_valid_o        = out_valid_q;
  assign result_o.result_row   = row3_q;
  assign result_o.result_value = acc_q;
  assign result_o.last_row     = last3_q;

endmodule

### rtl/matrix_vector_multiply.sv
// Top level of the dense matrix-vector multiplier y = A * x.
//
// The block takes command transactions on start/busy with the payload in_i: a
// transaction is accepted at a rising edge where start is high and busy is low.
// A matrix load writes one element of A at (row_index, col_index), a vector load
// writes one element of x at col_index; loads can be issued back to back.
// Loads outside the stores are dropped.
// A start transaction runs the product over the configured rows and columns.
// The sequencer issues one multiply-accumulate per cycle out of the single read
// port of each store, and busy stays high while a run issues its slots.
// Each row's result passes the read, product and accumulator registers, carried
// by a one-cycle strobe on result_valid_o with result_o; the last result of a run
// has last_row set. The receiver cannot stall, so no result is ever held back.
// A start with zero rows gives no result; zero columns give zeros.
// Configuration goes through the cfg_valid_i/cfg_ready_o channel (index 0 is the
// row count, index 1 the column count); it is always ready and should only be
// written while no run is in flight. Reset sets both counts to four and returns
// the sequencer to idle; store contents are undefined until loaded.
module matrix_vector_multiply #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mvm_pkg::mvm_in_t               in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mvm_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output logic                           result_valid_o,
  output mvm_pkg::mvm_out_t              result_o
);
  import mvm_pkg::*;

`include "assert_macros.svh"

  mvm_issue_t issue;
  mvm_load_t  load;

  // The controller owns the configuration and walks rows and columns.
  mvm_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .issue_o    (issue),
    .load_o     (load)
  );

  // The datapath reads both stores, multiplies and accumulates each row.
  mvm_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .load_i        (load),
    .issue_i       (issue),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // A result leaves the pipeline only from a slot issued during a run.
  `MVM_ASSERT(a_result_from_run, result_valid_o |-> $past(busy, 3), "result without a run")

  // The final result of a run is never directly followed by another result.
  `MVM_ASSERT(a_gap_after_last, result_valid_o && result_o.last_row |=> !result_valid_o, "result right after last row")

  // A run ends only after the slot closing the last row was issued.
  `MVM_ASSERT(a_run_end, $fell(busy) |-> $past(issue.last_row && issue.last_col), "run ended early")

endmodule
